/* sv/embedding_pair_gradient_update_assert.svh */
// Assertion macros for the checker file of the embedding update block.
`ifndef EMBEDDING_PAIR_GRADIENT_UPDATE_ASSERT_SVH
`define EMBEDDING_PAIR_GRADIENT_UPDATE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define EPGU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define EPGU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/epgu_pkg.sv */
// Shared types, codes and helpers of the embedding pair gradient update block.
package epgu_pkg;

  // action codes of a request
  localparam logic [2:0] ActLoad    = 3'd0;
  localparam logic [2:0] ActAttract = 3'd1;
  localparam logic [2:0] ActRepulse = 3'd2;
  localparam logic [2:0] ActEnd     = 3'd3;
  localparam logic [2:0] ActRead    = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CfgLearningRate      = 3'd0;
  localparam logic [2:0] CfgMaxIterations     = 3'd1;
  localparam logic [2:0] CfgRepulsiveSamples  = 3'd2;
  localparam logic [2:0] CfgEarlyExaggeration = 3'd3;
  localparam logic [2:0] CfgNodeCount         = 3'd4;

  localparam logic [31:0] OneQ31         = 32'h8000_0000;
  // eta floor: x / 10000 == (x * ceil(2^45 / 10000)) >> 45 for any 32-bit x
  localparam logic [32:0] EtaFloorRecip  = 33'd3518437209;
  localparam int          EtaFloorShift  = 45;
  localparam logic [35:0] EarlyDiv       = 36'd10;
  localparam int          CoefShiftEarly = 3;  // x8
  localparam int          CoefShiftLate  = 1;  // x2
  localparam logic [40:0] ScaleCap       = 41'h100_0000_0000;
  localparam logic [33:0] GainCap        = 34'h2_0000_0000;

  typedef struct packed {
    logic [2:0]         action;
    logic [11:0]        node_a;
    logic [11:0]        node_b;
    logic               axis;
    logic signed [31:0] coordinate;
  } in_req_t;

  typedef struct packed {
    logic               status;
    logic signed [31:0] read_value;
    logic [31:0]        similarity;
    logic [31:0]        mean_similarity;
    logic [31:0]        iteration;
  } out_rsp_t;

  typedef struct packed {
    logic [31:0] learning_rate;
    logic [31:0] max_iterations;
    logic [6:0]  repulsive_samples;
    logic        early_exaggeration;
    logic [12:0] node_count;
  } cfg_t;

  // classified request
  typedef enum logic [2:0] {
    OP_LOAD, OP_ATTRACT, OP_REPULSE, OP_END, OP_READ, OP_SKIP, OP_NOP
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [11:0]        node_a;
    logic [11:0]        node_b;
    logic               axis;
    logic signed [31:0] coordinate;
  } job_t;

  function automatic logic [31:0] sat32(input logic signed [35:0] x);
    logic [31:0] r;
    if (x > 36'sd2147483647) r = 32'h7FFF_FFFF;
    else if (x < -36'sd2147483648) r = 32'h8000_0000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

/* sv/embedding_pair_gradient_update.sv */
// Pairs and ends of iteration use the shared bit-serial divider (1 to 3 divides per pair,
// 1 per end of iteration). Past the schedule the decay divide drops out.
// One request in flight in the back end; a 2-entry queue takes requests ahead.
// Reset (async, active low): queue empty, mean similarity 1.0, sums, counts and iteration
// zero, registers to defaults; position memory is not cleared (undefined until written).
module embedding_pair_gradient_update #(
  parameter int MAX_NODES = 4096,
  parameter int DIMS      = 2,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  epgu_pkg::in_req_t  in_req_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output epgu_pkg::out_rsp_t out_rsp_o,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  epgu_pkg::cfg_t cfg_q;
  epgu_pkg::job_t head;
  logic           head_valid, pop;

  // config writes are always accepted
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.learning_rate      <= 32'd65536;
      cfg_q.max_iterations     <= 32'd1000;
      cfg_q.repulsive_samples  <= 7'd5;
      cfg_q.early_exaggeration <= 1'b1;
      cfg_q.node_count         <= 13'd4096;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        epgu_pkg::CfgLearningRate:      cfg_q.learning_rate      <= cfg_data_i;
        epgu_pkg::CfgMaxIterations:     cfg_q.max_iterations     <= cfg_data_i;
        epgu_pkg::CfgRepulsiveSamples:  cfg_q.repulsive_samples  <= cfg_data_i[6:0];
        epgu_pkg::CfgEarlyExaggeration: cfg_q.early_exaggeration <= cfg_data_i[0];
        epgu_pkg::CfgNodeCount:         cfg_q.node_count         <= cfg_data_i[12:0];
        default: begin
        end
      endcase
    end
  end

  // front: classify each request (skip, out-of-range) and queue it
  epgu_front #(
    .MAX_NODES (MAX_NODES),
    .DIMS      (DIMS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_req_i     (in_req_i),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // back: memory, pair math sequencer, running statistics, result register
  epgu_back #(
    .MAX_NODES (MAX_NODES),
    .DIMS      (DIMS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_rsp_o    (out_rsp_o)
  );

endmodule

/* sv/epgu_front.sv */
// Front end: takes requests, classifies them and queues them for the back end.
module epgu_front #(
  parameter int MAX_NODES = 4096,
  parameter int DIMS      = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  epgu_pkg::in_req_t in_req_i,
  input  logic              pop_i,
  output logic              head_valid_o,
  output epgu_pkg::job_t    head_o
);

  epgu_pkg::job_t job;
  epgu_pkg::job_t fifo_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           push, pop, a_ok, b_ok, ax_ok;

  always_comb begin
    a_ok  = 32'(in_req_i.node_a) < 32'(MAX_NODES);
    b_ok  = 32'(in_req_i.node_b) < 32'(MAX_NODES);
    ax_ok = 32'(in_req_i.axis) < 32'(DIMS);
    job.node_a     = in_req_i.node_a;
    job.node_b     = in_req_i.node_b;
    job.axis       = in_req_i.axis;
    job.coordinate = in_req_i.coordinate;
    case (in_req_i.action)
      epgu_pkg::ActLoad: begin
        job.op = (a_ok && ax_ok) ? epgu_pkg::OP_LOAD : epgu_pkg::OP_NOP;
      end
      epgu_pkg::ActAttract, epgu_pkg::ActRepulse: begin
        if (in_req_i.node_a == in_req_i.node_b || !a_ok || !b_ok) begin
          job.op = epgu_pkg::OP_SKIP;
        end else if (in_req_i.action == epgu_pkg::ActAttract) begin
          job.op = epgu_pkg::OP_ATTRACT;
        end else begin
          job.op = epgu_pkg::OP_REPULSE;
        end
      end
      epgu_pkg::ActEnd: begin
        job.op = epgu_pkg::OP_END;
      end
      epgu_pkg::ActRead: begin
        job.op = (a_ok && ax_ok) ? epgu_pkg::OP_READ : epgu_pkg::OP_NOP;
      end
      default: begin
        job.op = epgu_pkg::OP_NOP;
      end
    endcase
  end

  assign in_stall_o   = (cnt_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign pop          = pop_i && (cnt_q != 2'd0);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= job;
  end

endmodule

/* sv/epgu_div.sv */
// Restoring divider, one quotient bit per cycle, 64-bit operands.
module epgu_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [63:0] quot_o
);

  logic [63:0] rem_q, qn_q, den_q;
  logic [6:0]  cnt_q;
  logic        busy_q, done_q, ge;
  logic [64:0] shifted, diff;

  always_comb begin
    shifted = {rem_q, qn_q[63]};
    ge      = shifted >= {1'b0, den_q};
    diff    = shifted - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      qn_q   <= '0;
      den_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= '0;
        qn_q   <= num_i;
        den_q  <= den_i;
        cnt_q  <= 7'd64;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= ge ? diff[63:0] : shifted[63:0];
        qn_q  <= {qn_q[62:0], ge};
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = qn_q;

endmodule

/* sv/epgu_back.sv */
// Back end: position memory, pair gradient sequencer and result register.
module epgu_back #(
  parameter int MAX_NODES = 4096,
  parameter int DIMS      = 2,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  epgu_pkg::cfg_t     cfg_i,
  input  logic               head_valid_i,
  input  epgu_pkg::job_t     head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output epgu_pkg::out_rsp_t out_rsp_o
);

  localparam int Depth = MAX_NODES * DIMS;
  localparam int AW    = $clog2(Depth);
  localparam int DW    = (DIMS > 1) ? $clog2(DIMS) : 1;

  typedef enum logic [25:0] {
    S_IDLE = 26'd1 << 0,  S_RDW  = 26'd1 << 1,  S_PRD  = 26'd1 << 2,
    S_PRDW = 26'd1 << 3,  S_DY   = 26'd1 << 4,  S_SQ   = 26'd1 << 5,
    S_Q    = 26'd1 << 6,  S_Q2   = 26'd1 << 7,  S_EQR  = 26'd1 << 8,
    S_G    = 26'd1 << 9,  S_ETA  = 26'd1 << 10, S_ETD  = 26'd1 << 11,
    S_DEC  = 26'd1 << 12, S_FLO  = 26'd1 << 13, S_SC   = 26'd1 << 14,
    S_GM   = 26'd1 << 15, S_UPD  = 26'd1 << 16, S_WR   = 26'd1 << 17,
    S_EN   = 26'd1 << 18, S_ES   = 26'd1 << 19, S_EF   = 26'd1 << 20,
    S_MUL1 = 26'd1 << 21, S_MUL2 = 26'd1 << 22, S_MUL3 = 26'd1 << 23,
    S_DIVW = 26'd1 << 24, S_DONE = 26'd1 << 25
  } state_e;

  function automatic logic [AW-1:0] addr_of(input logic [11:0] node, input logic [31:0] dsel);
    logic [31:0] lin;
    lin = 32'(node) * 32'(DIMS) + dsel;
    return lin[AW-1:0];
  endfunction

  state_e             state_q, ret_q;
  epgu_pkg::op_e      job_op_q;
  logic [11:0]        job_a_q, job_b_q;
  logic               side_q;
  logic [DW-1:0]      d_q;
  logic signed [31:0] yk_q [DIMS];
  logic signed [31:0] yl_q [DIMS];
  logic [32:0]        mag_q [DIMS];
  logic               neg_q [DIMS];
  logic [63:0]        sum_q, g_q, mx_q;
  logic [31:0]        q2_q, dec_q, eq_q, qcnt_q, iter_q;
  logic [40:0]        s_q;
  logic [25:0]        nsq_q;
  logic [32:0]        my_q;
  logic [64:0]        pp_q;
  logic [96:0]        prod_q;
  logic [47:0]        qsum_q;
  logic               div_start_q;
  logic [63:0]        div_num_q, div_den_q;
  logic               div_done;
  logic [63:0]        div_quot;
  logic               res_status_q;
  logic [31:0]        res_rd_q, res_sim_q;
  logic               out_valid_q;
  epgu_pkg::out_rsp_t out_rsp_q;

  logic [31:0] mem [Depth];
  logic [31:0] rd_data_q;
  logic        mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0] mem_wdata;

  // derived operands
  logic [31:0]        mi_eff, eq_eff, eta, flo;
  logic [6:0]         r_eff;
  logic [12:0]        n_eff;
  logic [35:0]        it10;
  logic               early, dlast, invert;
  logic signed [32:0] dy;
  logic [32:0]        dmag;
  logic [64:0]        sum_ext;
  logic [63:0]        sum_new;
  logic [65:0]        s_sh;
  logic [40:0]        s_new;
  logic [96:0]        p_sh;
  logic [33:0]        gm;
  logic signed [35:0] gain, k_ext, l_ext;
  logic [48:0]        qs_ext;

  always_comb begin
    mi_eff  = (cfg_i.max_iterations == 32'd0) ? 32'd1 : cfg_i.max_iterations;
    r_eff   = (cfg_i.repulsive_samples == 7'd0) ? 7'd1 : cfg_i.repulsive_samples;
    n_eff   = (cfg_i.node_count < 13'd2) ? 13'd2 : cfg_i.node_count;
    eq_eff  = (eq_q == 32'd0) ? 32'd1 : eq_q;
    it10    = ({4'b0, iter_q} << 3) + ({4'b0, iter_q} << 1) + epgu_pkg::EarlyDiv;
    early   = cfg_i.early_exaggeration && (it10 <= {4'b0, mi_eff});
    dlast   = (d_q == DW'(DIMS - 1));
    dy      = {yk_q[d_q][31], yk_q[d_q]} - {yl_q[d_q][31], yl_q[d_q]};
    dmag    = dy[32] ? 33'(-dy) : 33'(dy);
    sum_ext = {1'b0, sum_q} + prod_q[64:0];
    sum_new = sum_ext[64] ? '1 : sum_ext[63:0];
    s_sh    = prod_q[96:31];
    s_new   = (s_sh > 66'(epgu_pkg::ScaleCap)) ? epgu_pkg::ScaleCap : s_sh[40:0];
    p_sh    = prod_q >> FRAC_BITS;
    gm      = (p_sh > 97'(epgu_pkg::GainCap)) ? epgu_pkg::GainCap : p_sh[33:0];
    invert  = (job_op_q == epgu_pkg::OP_ATTRACT) != neg_q[d_q];
    gain    = invert ? -$signed({2'b0, gm}) : $signed({2'b0, gm});
    k_ext   = {{4{yk_q[d_q][31]}}, yk_q[d_q]} + gain;
    l_ext   = {{4{yl_q[d_q][31]}}, yl_q[d_q]} - gain;
    flo     = prod_q[epgu_pkg::EtaFloorShift +: 32];
    eta     = (dec_q > flo) ? dec_q : flo;
    qs_ext  = {1'b0, qsum_q} + 49'(div_quot[31:0]);
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_of(head_i.node_a, 32'(head_i.axis));
    mem_wdata = head_i.coordinate;
    mem_raddr = addr_of(head_i.node_a, 32'(head_i.axis));
    case (state_q)
      S_IDLE: begin
        mem_we = head_valid_i && (head_i.op == epgu_pkg::OP_LOAD);
      end
      S_PRD: begin
        mem_raddr = addr_of(side_q ? job_b_q : job_a_q, 32'(d_q));
      end
      S_WR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_of(side_q ? job_b_q : job_a_q, 32'(d_q));
        mem_wdata = side_q ? yl_q[d_q] : yk_q[d_q];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_q <= mem[mem_raddr];
  end

  assign pop_o = (state_q == S_IDLE) && head_valid_i;

  epgu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (div_num_q),
    .den_i   (div_den_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ret_q        <= S_IDLE;
      job_op_q     <= epgu_pkg::OP_NOP;
      job_a_q      <= '0;
      job_b_q      <= '0;
      side_q       <= 1'b0;
      d_q          <= '0;
      for (int i = 0; i < DIMS; i++) begin
        yk_q[i]  <= '0;
        yl_q[i]  <= '0;
        mag_q[i] <= '0;
        neg_q[i] <= 1'b0;
      end
      sum_q        <= '0;
      g_q          <= '0;
      mx_q         <= '0;
      my_q         <= '0;
      pp_q         <= '0;
      prod_q       <= '0;
      q2_q         <= '0;
      dec_q        <= '0;
      s_q          <= '0;
      nsq_q        <= '0;
      eq_q         <= epgu_pkg::OneQ31;
      qsum_q       <= '0;
      qcnt_q       <= '0;
      iter_q       <= '0;
      div_start_q  <= 1'b0;
      div_num_q    <= '0;
      div_den_q    <= '0;
      res_status_q <= 1'b0;
      res_rd_q     <= '0;
      res_sim_q    <= '0;
      out_valid_q  <= 1'b0;
      out_rsp_q    <= '0;
    end else begin
      // start pulse lasts one cycle; the sequencer sits in S_DIVW meanwhile
      if (div_start_q) div_start_q <= 1'b0;
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (head_valid_i) begin
            job_op_q     <= head_i.op;
            job_a_q      <= head_i.node_a;
            job_b_q      <= head_i.node_b;
            res_status_q <= (head_i.op == epgu_pkg::OP_SKIP);
            res_rd_q     <= '0;
            res_sim_q    <= '0;
            case (head_i.op)
              epgu_pkg::OP_SKIP: begin
                state_q <= S_DONE;
              end
              epgu_pkg::OP_READ: begin
                state_q <= S_RDW;
              end
              epgu_pkg::OP_ATTRACT, epgu_pkg::OP_REPULSE: begin
                sum_q   <= '0;
                side_q  <= 1'b0;
                d_q     <= '0;
                state_q <= S_PRD;
              end
              epgu_pkg::OP_END: begin
                mx_q    <= 64'(n_eff);
                my_q    <= 33'(n_eff - 13'd1);
                ret_q   <= S_EN;
                state_q <= S_MUL1;
              end
              default: begin
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_RDW: begin
          res_rd_q <= rd_data_q;
          state_q  <= S_DONE;
        end
        S_PRD: begin
          state_q <= S_PRDW;
        end
        S_PRDW: begin
          if (!side_q) begin
            yk_q[d_q] <= rd_data_q;
            side_q    <= 1'b1;
            state_q   <= S_PRD;
          end else begin
            yl_q[d_q] <= rd_data_q;
            side_q    <= 1'b0;
            if (dlast) begin
              d_q     <= '0;
              state_q <= S_DY;
            end else begin
              d_q     <= d_q + DW'(1);
              state_q <= S_PRD;
            end
          end
        end
        S_DY: begin
          mag_q[d_q] <= dmag;
          neg_q[d_q] <= dy[32];
          mx_q       <= 64'(dmag);
          my_q       <= dmag;
          ret_q      <= S_SQ;
          state_q    <= S_MUL1;
        end
        S_SQ: begin
          sum_q <= sum_new;
          if (dlast) begin
            d_q         <= '0;
            div_start_q <= 1'b1;
            div_num_q   <= 64'd1 << (31 + FRAC_BITS);
            div_den_q   <= (64'd1 << FRAC_BITS) + (sum_new >> FRAC_BITS);
            ret_q       <= S_Q;
            state_q     <= S_DIVW;
          end else begin
            d_q     <= d_q + DW'(1);
            state_q <= S_DY;
          end
        end
        S_Q: begin
          res_sim_q <= div_quot[31:0];
          qsum_q    <= qs_ext[48] ? '1 : qs_ext[47:0];
          if (qcnt_q != '1) qcnt_q <= qcnt_q + 32'd1;
          if (job_op_q == epgu_pkg::OP_ATTRACT) begin
            g_q     <= {32'b0, div_quot[31:0]}
                       << (early ? epgu_pkg::CoefShiftEarly : epgu_pkg::CoefShiftLate);
            state_q <= S_ETA;
          end else begin
            mx_q    <= 64'(div_quot[31:0]);
            my_q    <= 33'(div_quot[31:0]);
            ret_q   <= S_Q2;
            state_q <= S_MUL1;
          end
        end
        S_Q2: begin
          q2_q    <= prod_q[62:31];
          mx_q    <= 64'(eq_eff);
          my_q    <= 33'(r_eff);
          ret_q   <= S_EQR;
          state_q <= S_MUL1;
        end
        S_EQR: begin
          div_start_q <= 1'b1;
          div_num_q   <= {q2_q, 32'b0};
          div_den_q   <= prod_q[63:0];
          ret_q       <= S_G;
          state_q     <= S_DIVW;
        end
        S_G: begin
          g_q     <= div_quot;
          state_q <= S_ETA;
        end
        S_ETA: begin
          if (iter_q >= mi_eff) begin
            // past the schedule: only the floor term, by reciprocal multiply
            dec_q   <= '0;
            mx_q    <= 64'(cfg_i.learning_rate);
            my_q    <= epgu_pkg::EtaFloorRecip;
            ret_q   <= S_FLO;
            state_q <= S_MUL1;
          end else begin
            mx_q    <= 64'(cfg_i.learning_rate);
            my_q    <= 33'(iter_q);
            ret_q   <= S_ETD;
            state_q <= S_MUL1;
          end
        end
        S_ETD: begin
          div_start_q <= 1'b1;
          div_num_q   <= prod_q[63:0];
          div_den_q   <= 64'(mi_eff);
          ret_q       <= S_DEC;
          state_q     <= S_DIVW;
        end
        S_DEC: begin
          dec_q   <= cfg_i.learning_rate - div_quot[31:0];
          mx_q    <= 64'(cfg_i.learning_rate);
          my_q    <= epgu_pkg::EtaFloorRecip;
          ret_q   <= S_FLO;
          state_q <= S_MUL1;
        end
        S_FLO: begin
          mx_q    <= g_q;
          my_q    <= 33'(eta);
          ret_q   <= S_SC;
          state_q <= S_MUL1;
        end
        S_SC: begin
          s_q     <= s_new;
          d_q     <= '0;
          state_q <= S_GM;
        end
        S_GM: begin
          mx_q    <= 64'(s_q);
          my_q    <= mag_q[d_q];
          ret_q   <= S_UPD;
          state_q <= S_MUL1;
        end
        S_UPD: begin
          yk_q[d_q] <= epgu_pkg::sat32(k_ext);
          yl_q[d_q] <= epgu_pkg::sat32(l_ext);
          if (dlast) begin
            d_q     <= '0;
            side_q  <= 1'b0;
            state_q <= S_WR;
          end else begin
            d_q     <= d_q + DW'(1);
            state_q <= S_GM;
          end
        end
        S_WR: begin
          if (!side_q) begin
            side_q <= 1'b1;
          end else begin
            side_q <= 1'b0;
            if (dlast) begin
              d_q     <= '0;
              state_q <= S_DONE;
            end else begin
              d_q <= d_q + DW'(1);
            end
          end
        end
        S_EN: begin
          nsq_q   <= prod_q[25:0];
          mx_q    <= 64'(eq_q);
          my_q    <= 33'(prod_q[25:0]);
          ret_q   <= S_ES;
          state_q <= S_MUL1;
        end
        S_ES: begin
          div_start_q <= 1'b1;
          div_num_q   <= prod_q[63:0] + 64'(qsum_q);
          div_den_q   <= 64'(nsq_q) + 64'(qcnt_q);
          ret_q       <= S_EF;
          state_q     <= S_DIVW;
        end
        S_EF: begin
          eq_q   <= (div_quot > 64'(epgu_pkg::OneQ31)) ? epgu_pkg::OneQ31 : div_quot[31:0];
          qsum_q <= '0;
          qcnt_q <= '0;
          if (iter_q != '1) iter_q <= iter_q + 32'd1;
          state_q <= S_DONE;
        end
        S_MUL1: begin
          pp_q    <= 65'(mx_q[31:0]) * 65'(my_q);
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          prod_q  <= 97'(pp_q);
          pp_q    <= 65'(mx_q[63:32]) * 65'(my_q);
          state_q <= S_MUL3;
        end
        S_MUL3: begin
          prod_q  <= prod_q + {pp_q, 32'b0};
          state_q <= ret_q;
        end
        S_DIVW: begin
          if (div_done) state_q <= ret_q;
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_rsp_q.status          <= res_status_q;
            out_rsp_q.read_value      <= res_rd_q;
            out_rsp_q.similarity      <= res_sim_q;
            out_rsp_q.mean_similarity <= eq_q;
            out_rsp_q.iteration       <= iter_q;
            out_valid_q               <= 1'b1;
            state_q                   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

/* sv/epgu_checker.sv */
// Port-level checker for the embedding update block, bound to the top level.
`include "embedding_pair_gradient_update_assert.svh"

module epgu_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input epgu_pkg::out_rsp_t out_rsp_o
);

  `EPGU_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_rsp_o), "stalled result changed")
  `EPGU_ASSERT_NOW(a_mean_cap, out_valid_o, out_rsp_o.mean_similarity <= epgu_pkg::OneQ31, "mean similarity above 1.0")
  `EPGU_ASSERT_NOW(a_sim_cap, out_valid_o, out_rsp_o.similarity <= epgu_pkg::OneQ31, "similarity above 1.0")
  `EPGU_ASSERT_NOW(a_skip_clean, out_valid_o && out_rsp_o.status, out_rsp_o.similarity == 32'd0 && out_rsp_o.read_value == 32'sd0, "skipped pair carries data")

endmodule

bind embedding_pair_gradient_update epgu_checker u_epgu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

/* tb/sv/tb_embedding_pair_gradient_update.sv */
// Self-checking testbench for the embedding pair gradient update block.
`timescale 1ns / 100ps

// Tracks the block's state and holds the results it should produce, oldest first.
class embed_tracker;
  logic [31:0] coord_mem [8192];
  logic [63:0] mean_q, q_sum;
  logic [31:0] q_count, iter_count;
  logic [31:0] eta0, max_iter;
  logic [6:0]  rep_samples;
  logic        early_on;
  logic [12:0] nodes;
  epgu_pkg::out_rsp_t pending_rsp [$];
  int mismatches;

  function new();
    mean_q = 64'h8000_0000;
    q_sum = '0;
    q_count = '0;
    iter_count = '0;
    eta0 = 32'd65536;
    max_iter = 32'd1000;
    rep_samples = 7'd5;
    early_on = 1'b1;
    nodes = 13'd4096;
    mismatches = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      epgu_pkg::CfgLearningRate:      eta0 = data;
      epgu_pkg::CfgMaxIterations:     max_iter = data;
      epgu_pkg::CfgRepulsiveSamples:  rep_samples = data[6:0];
      epgu_pkg::CfgEarlyExaggeration: early_on = data[0];
      epgu_pkg::CfgNodeCount:         nodes = data[12:0];
      default: ;
    endcase
  endfunction

  function logic signed [63:0] widen(logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function logic [31:0] clip32(logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  // min(floor(a*b / 2^sh), cap)
  function logic [127:0] scaled_product(logic [127:0] a, logic [127:0] b, int sh,
                                        logic [127:0] cap);
    logic [127:0] p;
    p = (a * b) >> sh;
    return (p > cap) ? cap : p;
  endfunction

  function logic [127:0] step_size();
    logic [127:0] mi, flo, dec;
    mi = (max_iter == 0) ? 128'd1 : 128'(max_iter);
    flo = 128'(eta0) / 128'd10000;
    dec = (128'(iter_count) >= mi) ? 128'd0 : 128'(eta0) - (128'(eta0) * iter_count) / mi;
    return (dec > flo) ? dec : flo;
  endfunction

  function logic [31:0] move_pair(int k, int l, bit attract);
    logic [127:0] mag [2];
    bit neg [2];
    logic [127:0] dist2, q, g, s, mi, q2, eq, r, gm;
    logic signed [63:0] dy, gain;
    dist2 = '0;
    for (int d = 0; d < 2; d++) begin
      dy = widen(coord_mem[k*2+d]) - widen(coord_mem[l*2+d]);
      neg[d] = dy < 0;
      mag[d] = neg[d] ? 128'(-dy) : 128'(dy);
      dist2 = dist2 + mag[d] * mag[d];
      if (dist2 > 128'hFFFF_FFFF_FFFF_FFFF) dist2 = 128'hFFFF_FFFF_FFFF_FFFF;
    end
    q = (128'd1 << 47) / ((128'd1 << 16) + (dist2 >> 16));
    mi = (max_iter == 0) ? 128'd1 : 128'(max_iter);
    if (attract) begin
      // heavier pull during the exaggerated opening iterations
      g = (early_on && 128'(iter_count) < mi / 10) ? q * 8 : q * 2;
    end else begin
      q2 = (q * q) >> 31;
      eq = (mean_q == 0) ? 128'd1 : 128'(mean_q);
      r = (rep_samples == 0) ? 128'd1 : 128'(rep_samples);
      g = ((2 * q2) << 31) / (eq * r);
    end
    s = scaled_product(step_size(), g, 31, 128'd1 << 40);
    for (int d = 0; d < 2; d++) begin
      gm = scaled_product(s, mag[d], 16, 128'd1 << 33);
      gain = (attract != neg[d]) ? -64'(gm) : 64'(gm);
      coord_mem[k*2+d] = clip32(widen(coord_mem[k*2+d]) + gain);
      coord_mem[l*2+d] = clip32(widen(coord_mem[l*2+d]) - gain);
    end
    q_sum = (128'(q_sum) + q > 128'hFFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF : q_sum + q[63:0];
    if (q_count != 32'hFFFF_FFFF) q_count++;
    return q[31:0];
  endfunction

  function void close_iteration();
    logic [127:0] n, nsq, v;
    n = (nodes < 2) ? 128'd2 : 128'(nodes);
    nsq = n * (n - 1);
    v = (128'(mean_q) * nsq + q_sum) / (nsq + q_count);
    mean_q = (v > 128'h8000_0000) ? 64'h8000_0000 : v[63:0];
    q_sum = '0;
    q_count = '0;
    if (iter_count != 32'hFFFF_FFFF) iter_count++;
  endfunction

  function void accept_request(epgu_pkg::in_req_t req);
    epgu_pkg::out_rsp_t rsp;
    rsp = '0;
    case (req.action)
      epgu_pkg::ActLoad: coord_mem[req.node_a*2+req.axis] = req.coordinate;
      epgu_pkg::ActAttract, epgu_pkg::ActRepulse: begin
        if (req.node_a == req.node_b) rsp.status = 1'b1;
        else rsp.similarity = move_pair(req.node_a, req.node_b,
                                        req.action == epgu_pkg::ActAttract);
      end
      epgu_pkg::ActEnd: close_iteration();
      epgu_pkg::ActRead: rsp.read_value = coord_mem[req.node_a*2+req.axis];
      default: ;
    endcase
    rsp.mean_similarity = mean_q[31:0];
    rsp.iteration = iter_count;
    pending_rsp.push_back(rsp);
  endfunction

  function void check_result(epgu_pkg::out_rsp_t got);
    epgu_pkg::out_rsp_t want;
    if (pending_rsp.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    want = pending_rsp.pop_front();
    if (got.status !== want.status || got.read_value !== want.read_value ||
        got.similarity !== want.similarity ||
        got.mean_similarity !== want.mean_similarity || got.iteration !== want.iteration) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: status %0d/%0d read %h/%h q %h/%h mean %h/%h iter %0d/%0d",
                 want.status, got.status, want.read_value, got.read_value,
                 want.similarity, got.similarity, want.mean_similarity,
                 got.mean_similarity, want.iteration, got.iteration);
    end
  endfunction
endclass

module tb_embedding_pair_gradient_update;

  localparam logic [2:0] ActFirstUnknown = 3'd5;
  localparam int IdleLimit = 20000;  // far above one pair plus a full stall burst
  localparam int DrainWait = 400;    // longest request latency with margin

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall_o;
  epgu_pkg::in_req_t in_req = '0;
  logic out_valid_o;
  logic out_stall = 1'b0;
  epgu_pkg::out_rsp_t out_rsp_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  embed_tracker tracker = new();
  bit calm = 1'b0;       // no idling on either side when set
  int idle_cycles = 0;
  int stall_left = 0;

  // points that have both axes written; only these are read or paired
  bit written [8192];
  int live_nodes [$];

  always #2 clk_i = ~clk_i;

  embedding_pair_gradient_update DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Result side: check accepted results, then pick the next stall level in bursts.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) tracker.check_result(out_rsp_o);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: any accepted transfer on any channel restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) || (cfg_valid && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IdleLimit) begin
      $display("tb_embedding_pair_gradient_update NOT OK");
      $finish;
    end
  end

  task automatic send_request(epgu_pkg::in_req_t req);
    int hits [$];
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req <= req;
    do @(posedge clk_i); while (in_stall_o);
    tracker.accept_request(req);
    if (req.action == epgu_pkg::ActLoad) begin
      written[req.node_a*2+req.axis] = 1'b1;
      hits = live_nodes.find_first_index(x) with (x == req.node_a);
      if (written[req.node_a*2] && written[req.node_a*2+1] && hits.size() == 0)
        live_nodes.push_back(req.node_a);
    end
  endtask

  // Leaves valid high; set_regs drops it after the last write.
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.write_reg(idx, data);
  endtask

  // Registers change only with nothing in flight.
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic set_regs(logic [31:0] lr, logic [31:0] mi, logic [6:0] rs, logic ee,
                          logic [12:0] nc);
    write_reg(epgu_pkg::CfgLearningRate, lr);
    write_reg(epgu_pkg::CfgMaxIterations, mi);
    write_reg(epgu_pkg::CfgRepulsiveSamples, {25'd0, rs});
    write_reg(epgu_pkg::CfgEarlyExaggeration, {31'd0, ee});
    write_reg(epgu_pkg::CfgNodeCount, {19'd0, nc});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_coord();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return 32'($urandom_range(0, 1 << 19)) - 32'd262144;  // within about +-4.0
  endfunction

  function automatic epgu_pkg::in_req_t make_req(logic [2:0] act, int a, int b, logic ax,
                                                 logic [31:0] c);
    epgu_pkg::in_req_t r;
    r.action = act;
    r.node_a = 12'(a);
    r.node_b = 12'(b);
    r.axis = ax;
    r.coordinate = c;
    return r;
  endfunction

  // One random request; mostly pair traffic over loaded points.
  task automatic send_random();
    int sel, a, b;
    sel = $urandom_range(0, 99);
    a = live_nodes[$urandom_range(0, live_nodes.size() - 1)];
    b = live_nodes[$urandom_range(0, live_nodes.size() - 1)];
    if (sel < 4) begin
      // bring a fresh point in, both axes
      a = $urandom_range(0, 4095);
      send_request(make_req(epgu_pkg::ActLoad, a, $urandom_range(0, 4095), 1'b0,
                            pick_coord()));
      send_request(make_req(epgu_pkg::ActLoad, a, $urandom_range(0, 4095), 1'b1,
                            pick_coord()));
    end else if (sel < 10) begin
      send_request(make_req(epgu_pkg::ActLoad, a, $urandom_range(0, 4095),
                            1'($urandom_range(0, 1)), pick_coord()));
    end else if (sel < 40) begin
      send_request(make_req(epgu_pkg::ActAttract, a, b, 1'($urandom_range(0, 1)),
                            $urandom()));
    end else if (sel < 70) begin
      send_request(make_req(epgu_pkg::ActRepulse, a, b, 1'($urandom_range(0, 1)),
                            $urandom()));
    end else if (sel < 78) begin
      send_request(make_req(epgu_pkg::ActEnd, $urandom_range(0, 4095),
                            $urandom_range(0, 4095), 1'($urandom_range(0, 1)), $urandom()));
    end else if (sel < 90) begin
      send_request(make_req(epgu_pkg::ActRead, a, $urandom_range(0, 4095),
                            1'($urandom_range(0, 1)), $urandom()));
    end else if (sel < 95) begin
      // equal nodes: skipped, any point will do
      a = $urandom_range(0, 4095);
      send_request(make_req($urandom_range(0, 1) ? epgu_pkg::ActAttract
                                                 : epgu_pkg::ActRepulse, a, a,
                            1'($urandom_range(0, 1)), $urandom()));
    end else begin
      send_request(make_req(ActFirstUnknown + 3'($urandom_range(0, 2)),
                            $urandom_range(0, 4095), $urandom_range(0, 4095),
                            1'($urandom_range(0, 1)), $urandom()));
    end
  endtask

  initial begin
    int seed_nodes [8];
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults written back explicitly
    set_regs(32'd65536, 32'd1000, 7'd5, 1'b1, 13'd4096);

    // directed: coordinate extremes on the corner points, then every action at least once
    seed_nodes = '{0, 4095, 12'hAAA, 12'h555, 1, 2, 3, 4};
    send_request(make_req(epgu_pkg::ActLoad, 0, 0, 1'b0, 32'h7FFF_FFFF));
    send_request(make_req(epgu_pkg::ActLoad, 0, 0, 1'b1, 32'h0000_0000));
    send_request(make_req(epgu_pkg::ActLoad, 4095, 4095, 1'b0, 32'h8000_0000));
    send_request(make_req(epgu_pkg::ActLoad, 4095, 4095, 1'b1, 32'hFFFF_FFFF));
    for (int i = 2; i < 8; i++) begin
      send_request(make_req(epgu_pkg::ActLoad, seed_nodes[i], 0, 1'b0, pick_coord()));
      send_request(make_req(epgu_pkg::ActLoad, seed_nodes[i], 0, 1'b1, pick_coord()));
    end
    send_request(make_req(epgu_pkg::ActRead, 0, 0, 1'b0, '0));
    send_request(make_req(epgu_pkg::ActRead, 4095, 0, 1'b1, '0));
    send_request(make_req(epgu_pkg::ActAttract, 0, 4095, 1'b0, '0));
    send_request(make_req(epgu_pkg::ActRepulse, 4095, 0, 1'b0, '0));
    send_request(make_req(epgu_pkg::ActAttract, 12'hAAA, 12'h555, 1'b0, '0));
    send_request(make_req(epgu_pkg::ActRepulse, 1, 2, 1'b0, '0));
    send_request(make_req(epgu_pkg::ActAttract, 3, 3, 1'b0, '0));
    send_request(make_req(epgu_pkg::ActEnd, 0, 0, 1'b0, '0));
    send_request(make_req(ActFirstUnknown + 3'd2, 4095, 4095, 1'b1, 32'hFFFF_FFFF));
    send_request(make_req(epgu_pkg::ActRead, 3, 0, 1'b1, '0));

    for (int i = 0; i < 400; i++) send_random();
    drain();

    // large step, single iteration, 64 repulsive samples, smallest node count
    set_regs(32'hFFFF_FFFF, 32'd1, 7'd64, 1'b0, 13'd2);
    for (int i = 0; i < 400; i++) send_random();
    drain();

    // zero step, endless schedule; zero samples and zero nodes fall back to their minimums
    set_regs(32'd0, 32'hFFFF_FFFF, 7'd0, 1'b1, 13'd0);
    for (int i = 0; i < 400; i++) send_random();
    drain();

    // short schedule so the early phase ends during the run; last part runs flat out
    set_regs(32'h0004_0000, 32'd30, 7'd127, 1'b1, 13'd4095);
    for (int i = 0; i < 500; i++) begin
      if (i == 300) calm = 1'b1;
      send_random();
    end
    in_valid <= 1'b0;
    while (tracker.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (tracker.mismatches == 0 && tracker.pending_rsp.size() == 0)
      $display("tb_embedding_pair_gradient_update OK");
    else
      $display("tb_embedding_pair_gradient_update NOT OK");
    $finish;
  end
endmodule
